@@ rtl/core/indexed_selector_homing_controller_unit_defines.svh @@
// assertion macros shared by the selector controller
`ifndef INDEXED_SELECTOR_HOMING_CONTROLLER_UNIT_DEFINES_SVH
`define INDEXED_SELECTOR_HOMING_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define ISHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define ISHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ishc_pkg.sv @@
`default_nettype none
package ishc_pkg;

	// default widths
	localparam int ISHC_INDEX_BITS = 8;
	localparam int ISHC_TICK_BITS = 16;

	// configuration register file
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_ADDR_BITS = 1;
	localparam int LAST_INDEX_BITS = 8;
	localparam int MARK_THR_BITS = 16;
	localparam logic [LAST_INDEX_BITS-1:0] LAST_INDEX_RESET = 8'd5;
	localparam logic [MARK_THR_BITS-1:0] MARK_THR_RESET = 16'd1024;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_LAST_INDEX = 1'b0,
		CFG_HOME_MARK_TICKS = 1'b1
	} cfg_reg_t;

	// operation codes
	typedef enum logic [2:0] {
		OP_HOME = 3'd0,
		OP_MOVE_TO = 3'd1,
		OP_MOVE_NEXT = 3'd2,
		OP_HOLD = 3'd3,
		OP_DISABLE = 3'd4,
		OP_SENSOR = 3'd5,
		OP_TICK = 3'd6
	} op_t;

	// motor commands
	typedef enum logic [2:0] {
		MC_NONE = 3'd0,
		MC_HOLD = 3'd1,
		MC_HOME_FAST = 3'd2,
		MC_HOME_SLOW = 3'd3,
		MC_MOVE_FAST = 3'd4,
		MC_MOVE_SLOW = 3'd5,
		MC_DISABLE = 3'd6
	} motor_cmd_t;

	// status codes
	typedef enum logic [3:0] {
		ST_NONE = 4'd0,
		ST_HOME_STARTED = 4'd1,
		ST_MOVE_STARTED = 4'd2,
		ST_DONE_MOVING = 4'd3,
		ST_OUT_OF_RANGE = 4'd4,
		ST_FOUND_TARGET = 4'd5,
		ST_HOMED = 4'd6,
		ST_NOT_HOME = 4'd7,
		ST_DONE_NEXT = 4'd8,
		ST_FOUND_NEXT = 4'd9,
		ST_DISP_NOT_HOMED = 4'd10,
		ST_IDLE_DETECT = 4'd11,
		ST_DISABLED = 4'd12,
		ST_HELD = 4'd13,
		ST_NEXT_STARTED = 4'd14
	} status_t;

	// motor mode, one-hot
	typedef enum logic [2:0] {
		MODE_OFF = 3'b001,
		MODE_HELD = 3'b010,
		MODE_RUN = 3'b100
	} mode_t;

	// deferred request kind
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_HOME = 2'd1,
		KIND_MOVE = 2'd2
	} kind_t;

endpackage
`default_nettype wire

@@ rtl/core/indexed_selector_homing_controller_unit.sv @@
// Rotary tube selector controller: one stepper, one optical index sensor.
// Input channel (in_valid/in_ready) carries one command or event per
// transaction: home, move to index, move next, hold, disable, sensor level
// change or step tick, with destination, sensor level and dispenser flag.
// Output channel (out_valid/out_ready) returns exactly one result per input
// transaction, in order: motor command, status, position, dispenser home
// request and the deferred request kind and index.
// The transaction is registered in the input stage on acceptance, then
// the flag logic updates the state and loads the result register.
// One transaction is taken per cycle while the receiver does not stall;
// the state update is short compare and increment logic.
// When the receiver stalls, the result register holds and the input stage
// keeps one transaction; in_ready drops only when both are full.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// clock edge; the user must make them only while no transaction is in flight, the block does not enforce it.
// Asynchronous reset clears the controller state: index zero, motor disabled, no
// deferred request, last_index 5 and home mark threshold 1024.
`default_nettype none
`include "indexed_selector_homing_controller_unit_defines.svh"
module indexed_selector_homing_controller_unit
	import ishc_pkg::*;
#(
	parameter int INDEX_BITS = ISHC_INDEX_BITS,
	parameter int TICK_BITS = ISHC_TICK_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration
	input wire logic cfg_write,
	input wire logic [CFG_ADDR_BITS-1:0] cfg_index,
	input wire logic [CFG_DATA_BITS-1:0] cfg_data,
	// input channel
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] operation,
	input wire logic [INDEX_BITS-1:0] destination,
	input wire logic sensor_high,
	input wire logic dispenser_homed,
	// output channel
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] motor_command,
	output logic [3:0] status,
	output logic [INDEX_BITS-1:0] position,
	output logic dispenser_home_request,
	output logic [1:0] deferred_kind,
	output logic [INDEX_BITS-1:0] deferred_index
);

	localparam int CMP_BITS = (INDEX_BITS > LAST_INDEX_BITS) ? INDEX_BITS : LAST_INDEX_BITS;
	localparam int TCMP_BITS = (TICK_BITS > MARK_THR_BITS) ? TICK_BITS : MARK_THR_BITS;

	// configuration registers
	logic [LAST_INDEX_BITS-1:0] last_index_q;
	logic [MARK_THR_BITS-1:0] mark_thr_q;

	// controller state
	logic [INDEX_BITS-1:0] cur_q, goal_q, saved_index_q;
	mode_t mode_q;
	kind_t saved_kind_q;
	logic next_mode_q, target_seen_q, homing_q, mark_entered_q;
	logic home_pending_q, counting_q, tick_en_q;
	logic [TICK_BITS-1:0] ticks_q;

	// input stage
	logic valid_s1;
	op_t op_s1;
	logic [INDEX_BITS-1:0] dest_s1;
	logic high_s1, homed_s1;

	// result register
	logic out_valid_q;
	motor_cmd_t mc_q;
	status_t st_q;
	logic req_q;

	// next values
	logic [INDEX_BITS-1:0] n_cur, n_goal, n_saved_index;
	mode_t n_mode;
	kind_t n_saved_kind;
	logic n_next_mode, n_target_seen, n_homing, n_mark_entered;
	logic n_home_pending, n_counting, n_tick_en;
	logic [TICK_BITS-1:0] n_ticks;
	motor_cmd_t n_mc;
	status_t n_st;
	logic n_req;

	logic advance;
	logic [CMP_BITS-1:0] last_x, dest_x, goal_x, cur_x;
	logic [TCMP_BITS-1:0] thr_x;

	// handshake
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= LAST_INDEX_RESET;
			mark_thr_q <= MARK_THR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_LAST_INDEX: last_index_q <= cfg_data[LAST_INDEX_BITS-1:0];
				CFG_HOME_MARK_TICKS: mark_thr_q <= cfg_data[MARK_THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op_t'(operation);
			dest_s1 <= destination;
			high_s1 <= sensor_high;
			homed_s1 <= dispenser_homed;
		end
	end

	// next state and result for the transaction in the input stage
	always_comb begin
		n_cur = cur_q;
		n_goal = goal_q;
		n_mode = mode_q;
		n_next_mode = next_mode_q;
		n_target_seen = target_seen_q;
		n_homing = homing_q;
		n_mark_entered = mark_entered_q;
		n_home_pending = home_pending_q;
		n_counting = counting_q;
		n_tick_en = tick_en_q;
		n_ticks = ticks_q;
		n_saved_kind = saved_kind_q;
		n_saved_index = saved_index_q;
		n_mc = MC_NONE;
		n_st = ST_NONE;
		n_req = 1'b0;

		last_x = CMP_BITS'(last_index_q);
		dest_x = CMP_BITS'(dest_s1);
		goal_x = CMP_BITS'(goal_q);
		cur_x = CMP_BITS'(cur_q);
		thr_x = TCMP_BITS'(mark_thr_q);

		unique case (op_s1)
			OP_HOME: begin
				if (!homed_s1) begin
					n_saved_kind = KIND_HOME;
					n_saved_index = '0;
					n_req = 1'b1;
					n_st = ST_DISP_NOT_HOMED;
				end else begin
					n_homing = 1'b1;
					n_cur = '0;
					n_mode = MODE_RUN;
					n_mc = MC_HOME_FAST;
					n_st = ST_HOME_STARTED;
				end
			end
			OP_MOVE_TO: begin
				if (!homed_s1) begin
					n_saved_kind = KIND_MOVE;
					n_saved_index = dest_s1;
					n_req = 1'b1;
					n_st = ST_DISP_NOT_HOMED;
				end else begin
					n_goal = dest_s1;
					n_target_seen = 1'b0;
					n_next_mode = 1'b0;
					priority if (home_pending_q) begin
						n_homing = 1'b1;
						n_cur = '0;
						n_mode = MODE_RUN;
						n_mc = MC_HOME_FAST;
						n_st = ST_HOME_STARTED;
					end else if (dest_x > last_x) begin
						n_st = ST_OUT_OF_RANGE;
					end else if (cur_q == dest_s1) begin
						n_mode = MODE_HELD;
						n_mc = MC_HOLD;
						n_st = ST_DONE_MOVING;
					end else begin
						n_mode = MODE_RUN;
						n_mc = MC_MOVE_FAST;
						n_st = ST_MOVE_STARTED;
					end
				end
			end
			OP_MOVE_NEXT: begin
				n_target_seen = 1'b0;
				n_next_mode = 1'b1;
				n_mode = MODE_RUN;
				n_mc = MC_MOVE_FAST;
				n_st = ST_NEXT_STARTED;
			end
			OP_HOLD: begin
				n_mode = MODE_HELD;
				n_mc = MC_HOLD;
				n_st = ST_HELD;
			end
			OP_DISABLE: begin
				n_mode = MODE_OFF;
				n_goal = '0;
				n_mc = MC_DISABLE;
				n_st = ST_DISABLED;
			end
			OP_SENSOR: begin
				if (mode_q == MODE_RUN) begin
					if (high_s1) begin
						// mark left the sensor
						priority if (homing_q && mark_entered_q) begin
							n_mark_entered = 1'b0;
							n_tick_en = 1'b0;
							if (!counting_q) begin
								// long mark: home found
								n_homing = 1'b0;
								n_mode = MODE_HELD;
								n_mc = MC_HOLD;
								n_st = ST_HOMED;
								if (home_pending_q) begin
									n_home_pending = 1'b0;
									if (cur_q != goal_q) begin
										// resume the move that homing replaced
										if (!homed_s1) begin
											n_saved_kind = KIND_MOVE;
											n_saved_index = goal_q;
											n_req = 1'b1;
											n_st = ST_DISP_NOT_HOMED;
										end else begin
											n_target_seen = 1'b0;
											n_next_mode = 1'b0;
											if (goal_x > last_x) begin
												n_st = ST_OUT_OF_RANGE;
											end else begin
												n_mode = MODE_RUN;
												n_mc = MC_MOVE_FAST;
												n_st = ST_MOVE_STARTED;
											end
										end
									end else begin
										n_st = ST_DONE_MOVING;
									end
								end
							end else begin
								n_mc = MC_HOME_FAST;
								n_st = ST_NOT_HOME;
							end
						end else if (target_seen_q) begin
							n_mode = MODE_HELD;
							n_mc = MC_HOLD;
							n_st = next_mode_q ? ST_DONE_NEXT : ST_DONE_MOVING;
						end
					end else begin
						// mark entered the sensor
						priority if (homing_q) begin
							n_mark_entered = 1'b1;
							n_tick_en = 1'b1;
							n_ticks = '0;
							n_counting = 1'b1;
							n_mc = MC_HOME_SLOW;
						end else if (next_mode_q) begin
							n_target_seen = 1'b1;
							n_mc = MC_MOVE_SLOW;
							n_st = ST_FOUND_NEXT;
						end else begin
							if (cur_x == last_x) begin
								n_cur = '0;
							end else begin
								n_cur = cur_q + 1'b1;
							end
							if (n_cur == goal_q) begin
								n_target_seen = 1'b1;
								n_mc = MC_MOVE_SLOW;
								n_st = ST_FOUND_TARGET;
							end
						end
					end
				end else if (mode_q == MODE_OFF && !high_s1) begin
					// detection while idle forces homing first
					n_home_pending = 1'b1;
					n_st = ST_IDLE_DETECT;
				end
			end
			OP_TICK: begin
				if (tick_en_q) begin
					if (ticks_q != '1) begin
						n_ticks = ticks_q + 1'b1;
					end
					if (TCMP_BITS'(n_ticks) >= thr_x) begin
						n_counting = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	// controller state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			goal_q <= '0;
			mode_q <= MODE_OFF;
			next_mode_q <= 1'b0;
			target_seen_q <= 1'b0;
			homing_q <= 1'b0;
			mark_entered_q <= 1'b0;
			home_pending_q <= 1'b0;
			counting_q <= 1'b0;
			tick_en_q <= 1'b0;
			ticks_q <= '0;
			saved_kind_q <= KIND_NONE;
			saved_index_q <= '0;
		end else if (advance) begin
			cur_q <= n_cur;
			goal_q <= n_goal;
			mode_q <= n_mode;
			next_mode_q <= n_next_mode;
			target_seen_q <= n_target_seen;
			homing_q <= n_homing;
			mark_entered_q <= n_mark_entered;
			home_pending_q <= n_home_pending;
			counting_q <= n_counting;
			tick_en_q <= n_tick_en;
			ticks_q <= n_ticks;
			saved_kind_q <= n_saved_kind;
			saved_index_q <= n_saved_index;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			mc_q <= n_mc;
			st_q <= n_st;
			req_q <= n_req;
		end
	end

	// outputs; position and deferred request follow the state just written
	assign out_valid = out_valid_q;
	assign motor_command = mc_q;
	assign status = st_q;
	assign position = cur_q;
	assign dispenser_home_request = req_q;
	assign deferred_kind = saved_kind_q;
	assign deferred_index = saved_index_q;

	// checks
	`ISHC_ASSERT_NEXT(a_stage_holds, valid_s1 && !advance, valid_s1 && $stable(op_s1), "input stage lost a stalled transaction")
	`ISHC_ASSERT_NEXT(a_result_loaded, advance, out_valid_q, "processed transaction gave no result")
	`ISHC_ASSERT_NOW(a_tick_follows_mark, 1'b1, tick_en_q == mark_entered_q, "tick counting out of step with mark tracking")
	`ISHC_ASSERT_NOW(a_homed_holds, out_valid_q && st_q == ST_HOMED, mc_q == MC_HOLD, "homed status without hold command")

endmodule
`default_nettype wire

@@ test/tb_indexed_selector_homing_controller_unit.sv @@
`default_nettype none
module tb_indexed_selector_homing_controller_unit;
	import ishc_pkg::*;

	localparam int IDX_W = ISHC_INDEX_BITS;
	localparam int TCK_W = ISHC_TICK_BITS;
	localparam logic [TCK_W-1:0] TICK_SAT = '1;

	// one command or event as presented on the input channel
	typedef struct packed {
		logic [2:0] op;
		logic [IDX_W-1:0] dest;
		logic high;
		logic homed;
	} selector_cmd_t;

	// one result as returned on the output channel
	typedef struct packed {
		logic [2:0] motor;
		logic [3:0] status;
		logic [IDX_W-1:0] position;
		logic request;
		logic [1:0] kind;
		logic [IDX_W-1:0] index;
	} selector_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [IDX_W-1:0] destination = '0;
	logic sensor_high = 1'b0;
	logic dispenser_homed = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] motor_command;
	logic [3:0] status;
	logic [IDX_W-1:0] position;
	logic dispenser_home_request;
	logic [1:0] deferred_kind;
	logic [IDX_W-1:0] deferred_index;

	indexed_selector_homing_controller_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.destination(destination),
		.sensor_high(sensor_high),
		.dispenser_homed(dispenser_homed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.motor_command(motor_command),
		.status(status),
		.position(position),
		.dispenser_home_request(dispenser_home_request),
		.deferred_kind(deferred_kind),
		.deferred_index(deferred_index)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// command backlog, predicted replies, error count
	selector_cmd_t cmd_queue[$];
	selector_reply_t reply_queue[$];
	int mismatches = 0;
	int cmd_count = 0;

	// selector model: configuration and state
	logic [IDX_W-1:0] cfg_last;
	logic [TCK_W-1:0] cfg_thr;
	logic [IDX_W-1:0] cur_idx;
	logic [IDX_W-1:0] goal_idx;
	logic [IDX_W-1:0] saved_idx;
	kind_t saved_kind;
	mode_t motor_mode;
	logic next_mode;
	logic target_seen;
	logic homing;
	logic mark_in;
	logic home_pend;
	logic counting;
	logic tick_en;
	logic [TCK_W-1:0] mark_ticks;

	// reply under construction
	motor_cmd_t r_motor;
	status_t r_status;
	logic r_req;

	task automatic reset_model();
		cfg_last = LAST_INDEX_RESET;
		cfg_thr = MARK_THR_RESET;
		cur_idx = '0;
		goal_idx = '0;
		saved_idx = '0;
		saved_kind = KIND_NONE;
		motor_mode = MODE_OFF;
		next_mode = 1'b0;
		target_seen = 1'b0;
		homing = 1'b0;
		mark_in = 1'b0;
		home_pend = 1'b0;
		counting = 1'b0;
		tick_en = 1'b0;
		mark_ticks = '0;
	endtask

	// remember the request and ask for dispenser homing when it is not homed
	function automatic logic dispenser_ok(logic homed, kind_t kind, logic [IDX_W-1:0] idx);
		if (homed)
			return 1'b1;
		saved_kind = kind;
		saved_idx = idx;
		r_req = 1'b1;
		r_status = ST_DISP_NOT_HOMED;
		return 1'b0;
	endfunction

	function automatic void begin_homing(logic homed);
		if (!dispenser_ok(homed, KIND_HOME, '0))
			return;
		homing = 1'b1;
		cur_idx = '0;
		motor_mode = MODE_RUN;
		r_motor = MC_HOME_FAST;
		r_status = ST_HOME_STARTED;
	endfunction

	function automatic void begin_move(logic [IDX_W-1:0] dest, logic homed);
		if (!dispenser_ok(homed, KIND_MOVE, dest))
			return;
		goal_idx = dest;
		target_seen = 1'b0;
		next_mode = 1'b0;
		if (home_pend) begin
			begin_homing(homed);
		end else if (goal_idx > cfg_last) begin
			r_status = ST_OUT_OF_RANGE;
		end else if (cur_idx == goal_idx) begin
			motor_mode = MODE_HELD;
			r_motor = MC_HOLD;
			r_status = ST_DONE_MOVING;
		end else begin
			motor_mode = MODE_RUN;
			r_motor = MC_MOVE_FAST;
			r_status = ST_MOVE_STARTED;
		end
	endfunction

	// advance the model by one transaction and return the reply it causes
	function automatic selector_reply_t predict_selector(selector_cmd_t cmd);
		r_motor = MC_NONE;
		r_status = ST_NONE;
		r_req = 1'b0;
		case (cmd.op)
			OP_HOME: begin_homing(cmd.homed);
			OP_MOVE_TO: begin_move(cmd.dest, cmd.homed);
			OP_MOVE_NEXT: begin
				target_seen = 1'b0;
				next_mode = 1'b1;
				motor_mode = MODE_RUN;
				r_motor = MC_MOVE_FAST;
				r_status = ST_NEXT_STARTED;
			end
			OP_HOLD: begin
				motor_mode = MODE_HELD;
				r_motor = MC_HOLD;
				r_status = ST_HELD;
			end
			OP_DISABLE: begin
				motor_mode = MODE_OFF;
				goal_idx = '0;
				r_motor = MC_DISABLE;
				r_status = ST_DISABLED;
			end
			OP_SENSOR: begin
				if (motor_mode == MODE_RUN) begin
					if (cmd.high) begin
						// mark left the sensor
						if (homing && mark_in) begin
							mark_in = 1'b0;
							tick_en = 1'b0;
							if (!counting) begin
								homing = 1'b0;
								motor_mode = MODE_HELD;
								r_motor = MC_HOLD;
								r_status = ST_HOMED;
								if (home_pend) begin
									home_pend = 1'b0;
									if (cur_idx != goal_idx)
										begin_move(goal_idx, cmd.homed);
									else
										r_status = ST_DONE_MOVING;
								end
							end else begin
								r_motor = MC_HOME_FAST;
								r_status = ST_NOT_HOME;
							end
						end else if (target_seen) begin
							motor_mode = MODE_HELD;
							r_motor = MC_HOLD;
							if (next_mode)
								r_status = ST_DONE_NEXT;
							else
								r_status = ST_DONE_MOVING;
						end
					end else begin
						// mark reached the sensor
						if (homing) begin
							mark_in = 1'b1;
							tick_en = 1'b1;
							mark_ticks = '0;
							counting = 1'b1;
							r_motor = MC_HOME_SLOW;
						end else if (next_mode) begin
							target_seen = 1'b1;
							r_motor = MC_MOVE_SLOW;
							r_status = ST_FOUND_NEXT;
						end else begin
							if (cur_idx == cfg_last)
								cur_idx = '0;
							else
								cur_idx = cur_idx + 1'b1;
							if (cur_idx == goal_idx) begin
								target_seen = 1'b1;
								r_motor = MC_MOVE_SLOW;
								r_status = ST_FOUND_TARGET;
							end
						end
					end
				end else if (motor_mode == MODE_OFF && !cmd.high) begin
					home_pend = 1'b1;
					r_status = ST_IDLE_DETECT;
				end
			end
			OP_TICK: begin
				if (tick_en) begin
					if (mark_ticks != TICK_SAT)
						mark_ticks = mark_ticks + 1'b1;
					if (mark_ticks >= cfg_thr)
						counting = 1'b0;
				end
			end
			default: ;
		endcase
		return '{motor: r_motor, status: r_status, position: cur_idx, request: r_req,
			kind: saved_kind, index: saved_idx};
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// input side: predict on every accepted transaction
	logic in_taken = 1'b0;
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			reply_queue.push_back(predict_selector('{operation, destination, sensor_high,
				dispenser_homed}));
			in_taken = 1'b1;
		end
	end

	// output side: compare each accepted result with the oldest prediction
	selector_reply_t reply_want;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (reply_queue.size() == 0) begin
				report_mismatch("result with no pending expectation");
			end else begin
				reply_want = reply_queue.pop_front();
				check_field("motor_command", motor_command, reply_want.motor);
				check_field("status", status, reply_want.status);
				check_field("position", position, reply_want.position);
				check_field("dispenser_home_request", dispenser_home_request,
					reply_want.request);
				check_field("deferred_kind", deferred_kind, reply_want.kind);
				check_field("deferred_index", deferred_index, reply_want.index);
			end
		end
	end

	// driver: bursts of transactions with random gaps
	int burst_left = 0;
	int gap_left = 0;
	selector_cmd_t next_cmd;
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			// offer stays until taken
		end else begin
			in_taken = 1'b0;
			if (!arst_n || gap_left != 0 || cmd_queue.size() == 0) begin
				if (arst_n && gap_left != 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				next_cmd = cmd_queue.pop_front();
				operation <= next_cmd.op;
				destination <= next_cmd.dest;
				sensor_high <= next_cmd.high;
				dispenser_homed <= next_cmd.homed;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// receiver: stall pattern of its own with a periodic long hold-off
	int rx_cycle = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_left = 0;
	always @(negedge clk) begin
		rx_cycle++;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_cycle % 1500 == 700) begin
			hold_left = 120;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(10, 80);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic logic [IDX_W-1:0] rnd_idx();
		return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
	endfunction

	function automatic logic rnd_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic add_item(logic [2:0] op, logic [IDX_W-1:0] dest, logic high, logic homed);
		cmd_queue.push_back('{op, dest, high, homed});
		cmd_count++;
	endtask

	task automatic add_ticks(int n);
		repeat (n) add_item(OP_TICK, rnd_idx(), rnd_bit(), rnd_bit());
	endtask

	task automatic add_steps(int n);
		repeat (n) begin
			add_item(OP_SENSOR, rnd_idx(), 1'b0, rnd_bit());
			add_item(OP_SENSOR, rnd_idx(), 1'b1, rnd_bit());
		end
	endtask

	// number of ticks for a mark, near the threshold when it is small
	function automatic int mark_len();
		if (cfg_thr <= 16)
			return $urandom_range(0, int'(cfg_thr) + 2);
		return $urandom_range(0, 12);
	endfunction

	function automatic logic [IDX_W-1:0] pick_dest();
		if ($urandom_range(0, 5) == 0)
			return rnd_idx();
		return IDX_W'($urandom_range(0, int'(cfg_last)));
	endfunction

	// one random sequence, mostly well formed
	task automatic add_scenario();
		int steps;
		steps = (int'(cfg_last) + 2 < 12) ? int'(cfg_last) + 2 : 12;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				// homing, with a retry when the mark was too short
				add_item(OP_HOME, rnd_idx(), rnd_bit(), $urandom_range(0, 6) != 0);
				repeat ($urandom_range(1, 2)) begin
					add_item(OP_SENSOR, rnd_idx(), 1'b0, rnd_bit());
					add_ticks(mark_len());
					add_item(OP_SENSOR, rnd_idx(), 1'b1, rnd_bit());
				end
			end
			3, 4, 5: begin
				add_item(OP_MOVE_TO, pick_dest(), rnd_bit(), $urandom_range(0, 6) != 0);
				add_steps($urandom_range(1, steps));
			end
			6: begin
				add_item(OP_MOVE_NEXT, rnd_idx(), rnd_bit(), rnd_bit());
				add_steps($urandom_range(1, 2));
			end
			7: begin
				// detection while idle forces homing before the move
				add_item(OP_DISABLE, rnd_idx(), rnd_bit(), rnd_bit());
				add_item(OP_SENSOR, rnd_idx(), 1'b0, rnd_bit());
				add_item(OP_MOVE_TO, pick_dest(), rnd_bit(), 1'b1);
				add_item(OP_SENSOR, rnd_idx(), 1'b0, rnd_bit());
				add_ticks((cfg_thr <= 16) ? int'(cfg_thr) + $urandom_range(0, 2) : 3);
				add_item(OP_SENSOR, rnd_idx(), 1'b1, rnd_bit());
				add_steps($urandom_range(1, steps));
			end
			8: begin
				add_item(OP_HOLD, rnd_idx(), rnd_bit(), rnd_bit());
				add_steps(1);
				add_item($urandom_range(0, 1) ? OP_HOME : OP_MOVE_TO, rnd_idx(), rnd_bit(),
					1'b0);
			end
			default: begin
				repeat ($urandom_range(1, 6))
					add_item(3'($urandom_range(0, 7)), rnd_idx(), rnd_bit(), rnd_bit());
			end
		endcase
	endtask

	task automatic wait_idle();
		while (!(cmd_queue.size() == 0 && !in_valid && reply_queue.size() == 0))
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(int budget);
		int start;
		start = cmd_count;
		while (cmd_count - start < budget)
			add_scenario();
		wait_idle();
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_LAST_INDEX: cfg_last = data[LAST_INDEX_BITS-1:0];
			CFG_HOME_MARK_TICKS: cfg_thr = data[MARK_THR_BITS-1:0];
			default: ;
		endcase
	endtask

	// run limit
	initial begin
		#40000000;
		$display("Some tests failed");
		$finish;
	end

	// reset, stimulus phases and final verdict
	initial begin
		reset_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at reset configuration
		add_item(3'd7, 8'hFF, 1'b1, 1'b1);
		add_item(OP_SENSOR, 8'h00, 1'b1, 1'b0);
		add_item(OP_SENSOR, 8'h00, 1'b0, 1'b0);
		add_item(OP_MOVE_TO, 8'd6, 1'b0, 1'b0);
		add_item(OP_HOME, 8'hFF, 1'b1, 1'b0);
		add_item(OP_MOVE_TO, 8'd2, 1'b0, 1'b1);
		add_item(OP_SENSOR, 8'h00, 1'b0, 1'b1);
		add_ticks(5);
		add_item(OP_SENSOR, 8'h00, 1'b1, 1'b1);
		add_steps(2);
		add_item(OP_MOVE_TO, 8'd2, 1'b0, 1'b1);
		add_item(OP_MOVE_TO, 8'd255, 1'b1, 1'b1);
		add_item(OP_MOVE_TO, 8'd6, 1'b0, 1'b1);
		add_item(OP_MOVE_TO, 8'd5, 1'b1, 1'b1);
		add_item(OP_MOVE_NEXT, 8'h00, 1'b0, 1'b0);
		add_steps(1);
		add_item(OP_HOLD, 8'hFF, 1'b1, 1'b0);
		add_item(OP_SENSOR, 8'h00, 1'b0, 1'b1);
		add_item(OP_DISABLE, 8'hFF, 1'b0, 1'b1);
		add_item(OP_HOME, 8'h00, 1'b0, 1'b1);
		add_item(OP_SENSOR, 8'hFF, 1'b0, 1'b1);
		add_ticks(3);
		add_item(OP_SENSOR, 8'hFF, 1'b1, 1'b0);
		add_item(OP_TICK, 8'h00, 1'b0, 1'b0);
		wait_idle();

		// widest index range, walk part of the way round
		write_reg(CFG_LAST_INDEX, {rnd_idx(), 8'd255});
		write_reg(CFG_HOME_MARK_TICKS, 16'd3);
		add_item(OP_HOME, rnd_idx(), rnd_bit(), 1'b1);
		add_item(OP_SENSOR, rnd_idx(), 1'b0, 1'b1);
		add_ticks(3);
		add_item(OP_SENSOR, rnd_idx(), 1'b1, 1'b1);
		add_item(OP_MOVE_TO, 8'd250, rnd_bit(), 1'b1);
		add_steps(60);
		run_phase(130);

		// lowered wrap point, index may sit above it
		write_reg(CFG_LAST_INDEX, {rnd_idx(), 8'd3});
		write_reg(CFG_HOME_MARK_TICKS, 16'd1);
		add_item(OP_MOVE_TO, 8'd1, rnd_bit(), 1'b1);
		add_steps(8);
		run_phase(130);

		// single tube
		write_reg(CFG_LAST_INDEX, {rnd_idx(), 8'd0});
		write_reg(CFG_HOME_MARK_TICKS, 16'd2);
		run_phase(110);

		// largest threshold, a mark far too short to reach it
		write_reg(CFG_LAST_INDEX, {rnd_idx(), 8'd7});
		write_reg(CFG_HOME_MARK_TICKS, 16'hFFFF);
		add_item(OP_HOME, rnd_idx(), rnd_bit(), 1'b1);
		add_item(OP_SENSOR, rnd_idx(), 1'b0, rnd_bit());
		add_ticks(20);
		add_item(OP_SENSOR, rnd_idx(), 1'b1, rnd_bit());
		run_phase(90);

		// random moderate setting
		write_reg(CFG_LAST_INDEX, {rnd_idx(), 8'($urandom_range(1, 15))});
		write_reg(CFG_HOME_MARK_TICKS, 16'($urandom_range(1, 8)));
		run_phase(190);

		repeat (10) @(posedge clk);
		if (mismatches == 0 && reply_queue.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/ishc_pkg.sv
rtl/core/indexed_selector_homing_controller_unit.sv
test/tb_indexed_selector_homing_controller_unit.sv
